>>> rtl/core/line_triangle_hit_test_unit_assert.svh
// assertion macros for the line/triangle hit test unit
`ifndef LINE_TRIANGLE_HIT_TEST_UNIT_ASSERT_SVH
`define LINE_TRIANGLE_HIT_TEST_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define LTH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked with the consequent starting in the cycle after the antecedent
`define LTH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/core/lth_pkg.sv
// package for the line/triangle hit test unit
package lth_pkg;
  localparam int CoordBits = 16;
  localparam int DiffBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int CrossBits = ProdBits + 1;
  localparam int DotBits   = CrossBits + DiffBits + 2;
  localparam int AddrBits  = 5;

  typedef enum logic [2:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_DIRECTION_X = 3'd3,
    REG_DIRECTION_Y = 3'd4,
    REG_DIRECTION_Z = 3'd5
  } reg_index_t;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic signed [ProdBits-1:0]  prod_t;
  typedef logic signed [CrossBits-1:0] cross_t;
  typedef logic signed [DotBits-1:0]   dot_t;
endpackage

>>> rtl/core/line_triangle_hit_test_unit.sv
// line/triangle hit test unit, five-stage pipeline
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------
//  triangle | in        | start & !busy          | vert_{a,b,c}_{x,y,z}
//  result   | out       | done strobe, one cycle | hit, parallel
//  config   | in        | apb write, pready = 1  | origin_*, direction_* (6 x 16b)
//
// one triangle per cycle; stage 1 loads at the transfer edge and the result
// strobe is set by the five register stages (diff, product, cross, product,
// dot/sign)
// busy is always low: the receiver cannot stall, so the pipe never stops
// rst clears valid bits and config registers; payload stages are not reset
module line_triangle_hit_test_unit
  import lth_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  vert_a_x,
  input  logic signed [15:0]  vert_a_y,
  input  logic signed [15:0]  vert_a_z,
  input  logic signed [15:0]  vert_b_x,
  input  logic signed [15:0]  vert_b_y,
  input  logic signed [15:0]  vert_b_z,
  input  logic signed [15:0]  vert_c_x,
  input  logic signed [15:0]  vert_c_y,
  input  logic signed [15:0]  vert_c_z,
  output logic                done,
  output logic                hit,
  output logic                parallel,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  coord_t cfg [6];
  logic   cfg_wr;
  logic [2:0] widx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel & penable & pwrite;
  assign widx   = paddr[AddrBits-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) cfg[i] <= '0;
    end else if (cfg_wr && widx < 3'd6) begin
      cfg[widx] <= pwdata[CoordBits-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (widx < 3'd6) prdata = {{(32-CoordBits){cfg[widx][CoordBits-1]}}, cfg[widx]};
  end

  coord_t v [3][3];
  assign v[0][0] = vert_a_x; assign v[0][1] = vert_a_y; assign v[0][2] = vert_a_z;
  assign v[1][0] = vert_b_x; assign v[1][1] = vert_b_y; assign v[1][2] = vert_b_z;
  assign v[2][0] = vert_c_x; assign v[2][1] = vert_c_y; assign v[2][2] = vert_c_z;

  logic [4:0] vld;

  // stage 1: edges e[k] = v[k+1]-v[k], offsets w[k] = origin - v[k]
  diff_t e1 [3][3];
  diff_t w1 [3][3];
  diff_t d1 [3];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        e1[k][i] <= DiffBits'(v[(k+1)%3][i]) - DiffBits'(v[k][i]);
        w1[k][i] <= DiffBits'(cfg[i]) - DiffBits'(v[k][i]);
      end
    end
    for (int i = 0; i < 3; i++) d1[i] <= DiffBits'(cfg[3+i]);
  end

  // stage 2: products for normal (e0 x e1) and w[k] x d
  prod_t np [6];
  prod_t wp [3][6];
  diff_t e2 [3][3];
  diff_t d2 [3];
  always_ff @(posedge clk) begin
    np[0] <= e1[0][1] * e1[1][2]; np[1] <= e1[0][2] * e1[1][1];
    np[2] <= e1[0][2] * e1[1][0]; np[3] <= e1[0][0] * e1[1][2];
    np[4] <= e1[0][0] * e1[1][1]; np[5] <= e1[0][1] * e1[1][0];
    for (int k = 0; k < 3; k++) begin
      wp[k][0] <= w1[k][1] * d1[2]; wp[k][1] <= w1[k][2] * d1[1];
      wp[k][2] <= w1[k][2] * d1[0]; wp[k][3] <= w1[k][0] * d1[2];
      wp[k][4] <= w1[k][0] * d1[1]; wp[k][5] <= w1[k][1] * d1[0];
    end
    e2 <= e1;
    d2 <= d1;
  end

  // stage 3: cross differences
  cross_t n3 [3];
  cross_t x3 [3][3];
  diff_t  e3 [3][3];
  diff_t  d3 [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      n3[i] <= CrossBits'(np[2*i]) - CrossBits'(np[2*i+1]);
      for (int k = 0; k < 3; k++)
        x3[k][i] <= CrossBits'(wp[k][2*i]) - CrossBits'(wp[k][2*i+1]);
    end
    e3 <= e2;
    d3 <= d2;
  end

  // stage 4: dot products terms
  dot_t ap [3];
  dot_t tp [3][3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ap[i] <= DotBits'(n3[i]) * DotBits'(d3[i]);
      for (int k = 0; k < 3; k++)
        tp[k][i] <= DotBits'(e3[k][i]) * DotBits'(x3[k][i]);
    end
  end

  // stage 5: sums and sign compare
  dot_t a5;
  dot_t t5 [3];
  logic ok;
  always_comb begin
    a5 = ap[0] + ap[1] + ap[2];
    ok = 1'b1;
    for (int k = 0; k < 3; k++) begin
      t5[k] = tp[k][0] + tp[k][1] + tp[k][2];
      if (t5[k] == '0 || (t5[k][DotBits-1] != a5[DotBits-1])) ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start};
    end
    parallel <= (a5 == '0);
    hit      <= (a5 != '0) & ok;
  end

  assign done = vld[4];

endmodule

>>> rtl/core/lth_checker.sv
// port-level checker for the line/triangle hit test unit
`include "line_triangle_hit_test_unit_assert.svh"
module lth_checker
  import lth_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic hit,
  input logic parallel,
  input logic pready
);
  `LTH_ASSERT_IMP(hit_not_parallel, done, !(hit && parallel))
  `LTH_ASSERT_IMP(never_busy, 1'b1, !busy)
  `LTH_ASSERT_IMP(ready_high, 1'b1, pready)
  `LTH_ASSERT_NEXT(done_follows, !start, ##4 !done)
endmodule

bind line_triangle_hit_test_unit lth_checker u_lth_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .hit(hit), .parallel(parallel), .pready(pready)
);
